// ===== rtl/sorted_table_search_unit_defines.svh =====
// Assertion macros shared by the sorted table search unit.
`ifndef SORTED_TABLE_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define STS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define STS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sts_pkg.sv =====
// Package: operation codes, controller states and control/status words.
package sts_pkg;

   localparam int REQ_VALUE_BITS = 32;
   localparam int OP_BITS        = 3;
   localparam int POS_BITS       = 6;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 3'd0,
      OP_EXISTS = 3'd1,
      OP_CEIL   = 3'd2,
      OP_FLOOR  = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE,
      ST_EXIST_RD,
      ST_EXIST_CMP,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_mid;
      logic step;
      logic rd_shift;
      logic wr_shift;
      logic wr_key;
      logic rd_lo;
      logic match;
      logic clear_fill;
      logic respond;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   search_done;
      logic   shift_done;
      logic   in_range;
   } status_type;

endpackage

// ===== rtl/sts_ctrl.sv =====
// Controller: sequences search probes, insert shifts and the response word.
module sts_ctrl
   import sts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (status.op)
               OP_INSERT: begin
                  state_in = status.full ? ST_RESPOND : ST_SRCH_RD;
               end
               OP_EXISTS, OP_CEIL, OP_FLOOR: begin
                  state_in = ST_SRCH_RD;
               end
               default: begin
                  state_in = ST_RESPOND;
               end
            endcase
         end
         ST_SRCH_RD: begin
            if (!status.search_done) begin
               state_in = ST_SRCH_CMP;
            end else begin
               case (status.op)
                  OP_INSERT: begin
                     state_in = ST_SHIFT_RD;
                  end
                  OP_EXISTS: begin
                     state_in = status.in_range ? ST_EXIST_RD : ST_RESPOND;
                  end
                  default: begin
                     state_in = ST_RESPOND;
                  end
               endcase
            end
         end
         ST_SRCH_CMP: begin
            state_in = ST_SRCH_RD;
         end
         ST_SHIFT_RD: begin
            state_in = status.shift_done ? ST_WRITE : ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            state_in = ST_SHIFT_RD;
         end
         ST_WRITE: begin
            state_in = ST_RESPOND;
         end
         ST_EXIST_RD: begin
            state_in = ST_EXIST_CMP;
         end
         ST_EXIST_CMP: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_DISPATCH: begin
            cmd.clear_fill = (status.op == OP_CLEAR);
         end
         ST_SRCH_RD: begin
            cmd.rd_mid = !status.search_done;
         end
         ST_SRCH_CMP: begin
            cmd.step = 1'b1;
         end
         ST_SHIFT_RD: begin
            cmd.rd_shift = !status.shift_done;
         end
         ST_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
         end
         ST_WRITE: begin
            cmd.wr_key = 1'b1;
         end
         ST_EXIST_RD: begin
            cmd.rd_lo = 1'b1;
         end
         ST_EXIST_CMP: begin
            cmd.match = 1'b1;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/sts_dp.sv =====
// Datapath: entry memory, search bounds, fill count and response registers.
`include "sorted_table_search_unit_defines.svh"
module sts_dp
   import sts_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cmd_type                           cmd,
   output status_type                        status,
   input  logic [OP_BITS-1:0]                req_op,
   input  logic signed [REQ_VALUE_BITS-1:0]  req_value,
   output logic                              rsp_strobe,
   output logic                              rsp_hit,
   output logic [POS_BITS-1:0]               rsp_position,
   output logic                              rsp_error
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [VALUE_BITS-1:0] entry_mem [DEPTH];

   op_type                op_ff, op_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic                  match_ff, match_in;
   logic                  err_ff, err_in;
   logic [VALUE_BITS-1:0] rdata_ff;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [POS_BITS-1:0]   rsp_position_ff, rsp_position_in;
   logic                  rsp_error_ff, rsp_error_in;

   logic [VALUE_BITS-1:0] value_ext;
   logic [VALUE_BITS-1:0] key_new;
   logic [CW-1:0]         mid;
   logic [CW-1:0]         idx_m1;
   logic                  strict;
   logic                  below;
   logic                  full;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;

   // Flip the sign bit so that an unsigned compare orders signed values.
   assign value_ext = VALUE_BITS'(req_value);
   assign key_new   = {~value_ext[VALUE_BITS-1], value_ext[VALUE_BITS-2:0]};

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_m1 = idx_ff - CW'(1);
   assign full   = (fill_ff >= CW'(DEPTH));
   assign strict = op_ff inside {OP_EXISTS, OP_CEIL};
   assign below  = strict ? (rdata_ff < key_ff) : (rdata_ff <= key_ff);

   assign status.op          = op_ff;
   assign status.full        = full;
   assign status.search_done = (lo_ff == hi_ff);
   assign status.shift_done  = (idx_ff == lo_ff);
   assign status.in_range    = (lo_ff < fill_ff);

   always_comb begin
      op_in    = op_ff;
      key_in   = key_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      fill_in  = fill_ff;
      match_in = match_ff;
      err_in   = err_ff;
      if (cmd.load) begin
         op_in    = op_type'(req_op);
         key_in   = key_new;
         lo_in    = '0;
         hi_in    = fill_ff;
         idx_in   = fill_ff;
         match_in = 1'b0;
         err_in   = (req_op == OP_INSERT) && full;
      end
      if (cmd.step) begin
         if (below) lo_in = mid + CW'(1);
         else hi_in = mid;
      end
      if (cmd.wr_shift) idx_in = idx_m1;
      if (cmd.match) match_in = (rdata_ff == key_ff);
      if (cmd.wr_key) fill_in = fill_ff + CW'(1);
      if (cmd.clear_fill) fill_in = '0;
   end

   always_comb begin
      rsp_strobe_in   = cmd.respond;
      rsp_hit_in      = 1'b0;
      rsp_position_in = '0;
      rsp_error_in    = 1'b0;
      case (op_ff)
         OP_INSERT: begin
            rsp_error_in = err_ff;
         end
         OP_EXISTS: begin
            rsp_hit_in = match_ff;
         end
         OP_CEIL: begin
            if (lo_ff < fill_ff) begin
               rsp_hit_in      = 1'b1;
               rsp_position_in = POS_BITS'(lo_ff);
            end
         end
         OP_FLOOR: begin
            if (lo_ff != '0) begin
               rsp_hit_in      = 1'b1;
               rsp_position_in = POS_BITS'(lo_ff - CW'(1));
            end
         end
         default: begin
            rsp_hit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      idx_ff   <= idx_in;
      match_ff <= match_in;
      err_ff   <= err_in;
      if (cmd.respond) begin
         rsp_hit_ff      <= rsp_hit_in;
         rsp_position_ff <= rsp_position_in;
         rsp_error_ff    <= rsp_error_in;
      end
   end

   // One read port, one write port; a shift moves the word read last cycle up one slot.
   assign rd_en   = cmd.rd_mid || cmd.rd_shift || cmd.rd_lo;
   assign rd_addr = cmd.rd_mid   ? mid[AW-1:0] :
                    cmd.rd_shift ? idx_m1[AW-1:0] : lo_ff[AW-1:0];
   assign wr_en   = cmd.wr_shift || cmd.wr_key;
   assign wr_addr = cmd.wr_shift ? idx_ff[AW-1:0] : lo_ff[AW-1:0];
   assign wr_data = cmd.wr_shift ? rdata_ff : key_ff;

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= entry_mem[rd_addr];
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_error    = rsp_error_ff;

   `STS_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(DEPTH), "fill over depth")
   `STS_ASSERT_IMP(a_shift_read, clock, reset, cmd.wr_shift, $past(cmd.rd_shift), "shift no read")
   `STS_ASSERT_IMP(a_probe_read, clock, reset, cmd.step, $past(cmd.rd_mid), "probe no read")
   `STS_ASSERT_NXT(a_insert_grow, clock, reset, cmd.wr_key,
                   fill_ff == $past(fill_ff) + CW'(1), "fill not grown")
   `STS_ASSERT_IMP(a_error_alone, clock, reset, rsp_strobe_ff && rsp_error_ff,
                   !rsp_hit_ff && rsp_position_ff == '0, "error with hit")

endmodule

// ===== rtl/sorted_table_search_unit.sv =====
// A query passes dispatch, the search probes and the respond state before rsp_strobe;
// exists adds a read and compare; insert adds a shift per moved entry, then the key write.
// Throughput: one word at a time, set by the entry memory probe loop;
// a new word is taken in the cycle the previous response is shown.
// Reset clears the fill count and the controller; table contents stay undefined,
// with no clearing pass. Responses cannot be stalled.
module sorted_table_search_unit
   import sts_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [OP_BITS-1:0]                req_op,
   input  logic signed [REQ_VALUE_BITS-1:0]  req_value,
   output logic                              rsp_strobe,
   output logic                              rsp_hit,
   output logic [POS_BITS-1:0]               rsp_position,
   output logic                              rsp_error
);

   cmd_type    cmd;
   status_type status;

   sts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   sts_dp #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_op       (req_op),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_hit      (rsp_hit),
      .rsp_position (rsp_position),
      .rsp_error    (rsp_error)
   );

endmodule

// ===== tb/sorted_table_search_unit_test.sv =====
// Self-checking testbench for the sorted table search unit: table, query and clear words.
`timescale 1ns / 100ps

import sts_pkg::*;

class search_scoreboard;
   typedef struct {
      logic                hit;
      logic [POS_BITS-1:0] position;
      logic                error;
   } answer_type;

   int unsigned                      depth;
   logic signed [REQ_VALUE_BITS-1:0] sorted_values[$];
   answer_type                       pending_answers[$];
   int unsigned                      failures;

   function new(int unsigned table_depth);
      depth    = table_depth;
      failures = 0;
   endfunction

   // Number of entries below the key, or at most the key when or_equal is set.
   function int unsigned count_below(logic signed [REQ_VALUE_BITS-1:0] key, bit or_equal);
      int unsigned n = 0;
      foreach (sorted_values[i]) begin
         if (sorted_values[i] < key || (or_equal && sorted_values[i] == key)) n++;
      end
      return n;
   endfunction

   function void note_word(logic [OP_BITS-1:0] op, logic signed [REQ_VALUE_BITS-1:0] value);
      answer_type  a;
      int unsigned at;
      a.hit      = 1'b0;
      a.position = '0;
      a.error    = 1'b0;
      case (op)
         OP_INSERT: begin
            if (sorted_values.size() >= depth) begin
               a.error = 1'b1;
            end else begin
               // land after equal values
               at = count_below(value, 1'b1);
               sorted_values.insert(at, value);
            end
         end
         OP_EXISTS: begin
            at = count_below(value, 1'b0);
            if (at < sorted_values.size() && sorted_values[at] == value) a.hit = 1'b1;
         end
         OP_CEIL: begin
            at = count_below(value, 1'b0);
            if (at < sorted_values.size()) begin
               a.hit      = 1'b1;
               a.position = at[POS_BITS-1:0];
            end
         end
         OP_FLOOR: begin
            at = count_below(value, 1'b1);
            if (at > 0) begin
               a.hit      = 1'b1;
               a.position = POS_BITS'(at - 1);
            end
         end
         OP_CLEAR: sorted_values.delete();
         default: ;
      endcase
      pending_answers.push_back(a);
   endfunction

   function void check_word(logic hit, logic [POS_BITS-1:0] position, logic error);
      answer_type a;
      if (pending_answers.size() == 0) begin
         $error("response word with no request outstanding");
         failures++;
         return;
      end
      a = pending_answers.pop_front();
      if (hit !== a.hit) begin
         $error("hit: expected %0d, got %0d", a.hit, hit);
         failures++;
      end
      if (position !== a.position) begin
         $error("position: expected %0d, got %0d", a.position, position);
         failures++;
      end
      if (error !== a.error) begin
         $error("error: expected %0d, got %0d", a.error, error);
         failures++;
      end
   endfunction
endclass

module sorted_table_search_unit_test;
   localparam int TABLE_DEPTH  = 64;
   localparam int PHASE_ITEMS  = 400;
   localparam logic signed [REQ_VALUE_BITS-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [REQ_VALUE_BITS-1:0] VAL_MAX = 32'sh7fff_ffff;

   logic                              clock;
   logic                              reset     = 1'b1;
   logic                              start     = 1'b0;
   logic                              busy;
   logic [OP_BITS-1:0]                req_op    = '0;
   logic signed [REQ_VALUE_BITS-1:0]  req_value = '0;
   logic                              rsp_strobe;
   logic                              rsp_hit;
   logic [POS_BITS-1:0]               rsp_position;
   logic                              rsp_error;

   search_scoreboard sb = new(TABLE_DEPTH);
   int unsigned      idle_pct = 0;
   int unsigned      words_sent = 0;

   sorted_table_search_unit #(
      .DEPTH      (TABLE_DEPTH),
      .VALUE_BITS (REQ_VALUE_BITS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_hit      (rsp_hit),
      .rsp_position (rsp_position),
      .rsp_error    (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("FAIL sorted_table_search_unit");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_word(rsp_hit, rsp_position, rsp_error);
   end

   // Idle on a share of the cycles in which the unit could take a word,
   // then hold the word until taken.
   task automatic send_word(logic [OP_BITS-1:0] op, logic signed [REQ_VALUE_BITS-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while (busy);
      end
      start     <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (busy);
      sb.note_word(op, value);
      words_sent++;
   endtask

   function automatic logic signed [REQ_VALUE_BITS-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 40) return $urandom_range(16) - 8;
      if (sel < 55) begin
         case ($urandom_range(5))
            0: return VAL_MIN;
            1: return VAL_MIN + 1;
            2: return VAL_MAX;
            3: return VAL_MAX - 1;
            4: return 0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // Aim keys at or next to stored entries half of the time.
   function automatic logic signed [REQ_VALUE_BITS-1:0] pick_key();
      int unsigned n;
      int          d;
      n = sb.sorted_values.size();
      if (n > 0 && $urandom_range(99) < 50) begin
         d = $urandom_range(2);
         return sb.sorted_values[$urandom_range(n - 1)] + d - 1;
      end
      return pick_value();
   endfunction

   task automatic run_random_round();
      int unsigned len;
      int unsigned ins_pct;
      int unsigned r;
      logic [OP_BITS-1:0] q_op;
      len = $urandom_range(120, 20);
      case ($urandom_range(2))
         0: ins_pct = 30;
         1: ins_pct = 60;
         default: ins_pct = 90;
      endcase
      send_word(OP_CLEAR, pick_value());
      repeat (len) begin
         r = $urandom_range(99);
         if (r < ins_pct) begin
            send_word(OP_INSERT, pick_value());
         end else begin
            r = $urandom_range(99);
            if (r < 2) begin
               send_word(OP_CLEAR, pick_value());
            end else if (r < 5) begin
               q_op = OP_BITS'($urandom_range(7, 5));
               send_word(q_op, pick_value());
            end else begin
               case ($urandom_range(2))
                  0: q_op = OP_EXISTS;
                  1: q_op = OP_CEIL;
                  default: q_op = OP_FLOOR;
               endcase
               send_word(q_op, pick_key());
            end
         end
      end
   endtask

   initial begin
      int unsigned phase_pct[5] = '{0, 76, 0, 22, 76};
      int unsigned phase_start;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table
      send_word(OP_EXISTS, 0);
      send_word(OP_CEIL, VAL_MIN);
      send_word(OP_FLOOR, VAL_MAX);
      // extremes and a duplicate
      send_word(OP_INSERT, 0);
      send_word(OP_INSERT, VAL_MAX);
      send_word(OP_INSERT, VAL_MIN);
      send_word(OP_INSERT, 0);
      send_word(OP_INSERT, -1);
      send_word(OP_EXISTS, 0);
      send_word(OP_EXISTS, 1);
      send_word(OP_EXISTS, VAL_MIN);
      send_word(OP_EXISTS, VAL_MAX);
      send_word(OP_CEIL, VAL_MIN);
      send_word(OP_CEIL, 1);
      send_word(OP_CEIL, VAL_MAX);
      send_word(OP_FLOOR, -2);
      send_word(OP_FLOOR, VAL_MAX);
      // unused codes
      send_word(3'd5, VAL_MAX);
      send_word(3'd6, VAL_MIN);
      send_word(3'd7, -1);
      // clear, then misses on either side
      send_word(OP_CLEAR, 0);
      send_word(OP_FLOOR, 0);
      send_word(OP_INSERT, 5);
      send_word(OP_FLOOR, 4);
      send_word(OP_CEIL, 6);

      foreach (phase_pct[p]) begin
         idle_pct    = phase_pct[p];
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_ITEMS) run_random_round();
      end

      start <= 1'b0;
      while (sb.pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0) begin
         $display("PASS sorted_table_search_unit");
      end else begin
         $display("FAIL sorted_table_search_unit");
      end
      $finish;
   end
endmodule
